[src/dbfg_pkg.sv]
// Package: shared constants, types and state codes for the de Bruijn fragment generator.
`default_nettype none
package dbfg_pkg;

  // Default sizing, used as the top-level parameter defaults
  localparam int DEF_MAX_ORDER   = 16;
  localparam int DEF_SYMBOL_BITS = 4;

  // Configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_DATA_W-1:0] ALPHABET_RESET = 5'd2;
  localparam logic [CFG_DATA_W-1:0] ORDER_RESET    = 5'd8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ALPHABET_SIZE = 4'd0,
    REG_ORDER         = 4'd1
  } cfg_reg_t;

  // OOK fragment codes, MSB first
  localparam int FRAG_W = 4;
  localparam logic [FRAG_W-1:0] FRAG_ZERO  = 4'b1000;
  localparam logic [FRAG_W-1:0] FRAG_OTHER = 4'b1110;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Request as queued by the front end
  typedef struct packed {
    logic valid;
    logic restart;
  } fe_req_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_COPY,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } st_t;

endpackage
`default_nettype wire

[src/dbfg_if.sv]
// Interfaces: request, result and configuration channels.
`default_nettype none

// Request channel: one restart flag per request
interface dbfg_req_if import dbfg_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// Result channel: symbol, fragment and last flag
interface dbfg_rsp_if import dbfg_pkg::*; #(
  parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) ();
  logic                   valid;
  logic                   ready;
  logic [SYMBOL_BITS-1:0] symbol;
  logic [FRAG_W-1:0]      fragment;
  logic                   last;

  modport source (output valid, output symbol, output fragment, output last, input ready);
  modport sink   (input valid, input symbol, input fragment, input last, output ready);
endinterface

// Configuration write channel
interface dbfg_cfg_if import dbfg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[src/de_bruijn_fragment_generator.sv]
// Top level: configuration registers, request queue and necklace sequencer.
// A queued request goes through the idle, emit and done states, then into the result register; a
// prefix end adds copy, scan and divisor test states between emit and done,
// repeated until the new prefix length divides the order.
// The sequencer holds one request at a time; a two-entry queue takes requests meanwhile.
// Sync reset clears the necklace, k=2, n=8.
`default_nettype none
module de_bruijn_fragment_generator import dbfg_pkg::*; #(
  parameter int MAX_ORDER   = DEF_MAX_ORDER,
  parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dbfg_req_if.sink   in_ch,
  dbfg_rsp_if.source out_ch,
  dbfg_cfg_if.sink   cfg_ch
);

  localparam int NW = $clog2(MAX_ORDER + 1);
  localparam int CW = ((SYMBOL_BITS + 1) > 5) ? (SYMBOL_BITS + 1) : 5;
  localparam int OW = (NW > CFG_DATA_W) ? NW : CFG_DATA_W;
  localparam logic [CW-1:0] KMAX = CW'(1 << SYMBOL_BITS);
  localparam logic [CW-1:0] KMIN = CW'(2);
  localparam logic [OW-1:0] NMAX = OW'(MAX_ORDER);

  logic [CFG_DATA_W-1:0] alpha_r;
  logic [CFG_DATA_W-1:0] order_r;
  logic                  cfg_wr;
  logic                  cfg_restart;
  logic [CW-1:0]         alpha_ext;
  logic [CW-1:0]         k_eff;
  logic [CW-1:0]         k_m1;
  logic [OW-1:0]         order_ext;
  logic [OW-1:0]         n_full;
  logic [NW-1:0]         n_eff;
  fe_req_t               fe_req;
  logic                  fe_pop;

  // Configuration writes
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  assign cfg_restart  = cfg_wr &&
                        ((cfg_ch.index == REG_ALPHABET_SIZE) || (cfg_ch.index == REG_ORDER));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHABET_RESET;
      order_r <= ORDER_RESET;
    end else if (cfg_wr) begin
      if (cfg_ch.index == REG_ALPHABET_SIZE) begin
        alpha_r <= cfg_ch.data;
      end
      if (cfg_ch.index == REG_ORDER) begin
        order_r <= cfg_ch.data;
      end
    end
  end

  // Clamp alphabet size and order to their usable ranges
  always_comb begin
    alpha_ext = CW'(alpha_r);
    if (alpha_ext < KMIN) begin
      k_eff = KMIN;
    end else if (alpha_ext > KMAX) begin
      k_eff = KMAX;
    end else begin
      k_eff = alpha_ext;
    end
    k_m1 = k_eff - 1'b1;

    order_ext = OW'(order_r);
    if (order_ext == '0) begin
      n_full = OW'(1);
    end else if (order_ext > NMAX) begin
      n_full = NMAX;
    end else begin
      n_full = order_ext;
    end
    n_eff = n_full[NW-1:0];
  end

  dbfg_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .pop    (fe_pop),
    .fe_req (fe_req)
  );

  dbfg_back #(
    .MAX_ORDER   (MAX_ORDER),
    .SYMBOL_BITS (SYMBOL_BITS),
    .NW          (NW),
    .CW          (CW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .k_m1        (k_m1),
    .n           (n_eff),
    .cfg_restart (cfg_restart),
    .fe_req      (fe_req),
    .fe_pop      (fe_pop),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire

[src/dbfg_front.sv]
// Front end: accepts requests and holds them in a short queue for the back end.
`default_nettype none
module dbfg_front import dbfg_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  dbfg_req_if.sink     in_ch,
  input  wire logic    pop,
  output fe_req_t      fe_req
);

  localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0]   LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [CNTW-1:0] DEPTH_C  = CNTW'(QUEUE_DEPTH);

  logic              q_r [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic              push;
  logic              do_pop;

  // Handshake and queue status
  assign in_ch.ready    = (cnt_r != DEPTH_C);
  assign push           = in_ch.valid && in_ch.ready;
  assign do_pop         = pop && (cnt_r != '0);
  assign fe_req.valid   = (cnt_r != '0);
  assign fe_req.restart = q_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_ch.restart;
    end
  end

endmodule
`default_nettype wire

[src/dbfg_back.sv]
// Back end: necklace sequencer (emit, copy, scan, divisor test) and result register.
`default_nettype none
module dbfg_back import dbfg_pkg::*; #(
  parameter int MAX_ORDER   = DEF_MAX_ORDER,
  parameter int SYMBOL_BITS = DEF_SYMBOL_BITS,
  parameter int NW          = $clog2(MAX_ORDER + 1),
  parameter int CW          = ((SYMBOL_BITS + 1) > 5) ? (SYMBOL_BITS + 1) : 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [CW-1:0] k_m1,
  input  wire logic [NW-1:0] n,
  input  wire logic          cfg_restart,
  input  wire fe_req_t       fe_req,
  output logic               fe_pop,
  dbfg_rsp_if.source         out_ch
);

  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  st_t                    state_r, state_nxt;
  logic [SYMBOL_BITS-1:0] nk_r [MAX_ORDER];
  logic [NW-1:0]          p_r, p_nxt;
  logic [NW-1:0]          e_r, e_nxt;
  logic [NW-1:0]          j_r, j_nxt;
  logic [NW-1:0]          i_r, i_nxt;
  logic [NW-1:0]          rem_r, rem_nxt;
  logic [SYMBOL_BITS-1:0] sym_r, sym_nxt;
  logic                   last_r, last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SYMBOL_BITS-1:0] out_sym_r;
  logic                   out_last_r;
  logic                   out_load;

  logic                   clr;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic [SYMBOL_BITS-1:0] wr_data;
  logic [IW-1:0]          rd_addr;
  logic [SYMBOL_BITS-1:0] rd_data;
  logic [NW-1:0]          i_m1;
  logic [NW:0]            e_inc;
  logic [NW:0]            jp_sum;
  logic                   bad;

  assign rd_data = nk_r[rd_addr];
  assign i_m1    = i_r - 1'b1;
  assign e_inc   = {1'b0, e_r} + 1'b1;
  assign jp_sum  = {1'b0, j_r} + {1'b0, p_r};
  assign bad     = (p_r == '0) || (p_r > n) || (e_r >= p_r);

  // Sequencer: next state, necklace access and result capture
  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    e_nxt     = e_r;
    j_nxt     = j_r;
    i_nxt     = i_r;
    rem_nxt   = rem_r;
    sym_nxt   = sym_r;
    last_nxt  = last_r;
    clr       = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    rd_addr   = '0;
    fe_pop    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (fe_req.valid) begin
          fe_pop    = 1'b1;
          state_nxt = ST_EMIT;
          if (fe_req.restart) begin
            clr   = 1'b1;
            p_nxt = NW'(1);
            e_nxt = '0;
          end
        end
      end
      ST_EMIT: begin
        rd_addr = e_r[IW-1:0];
        if (bad) begin
          // inconsistent prefix state: start over, then emit
          clr   = 1'b1;
          p_nxt = NW'(1);
          e_nxt = '0;
        end else begin
          sym_nxt = rd_data;
          if (e_inc >= {1'b0, p_r}) begin
            j_nxt     = '0;
            state_nxt = ST_COPY;
          end else begin
            e_nxt     = e_inc[NW-1:0];
            last_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_COPY: begin
        // periodic copy of the prefix across the necklace
        rd_addr = j_r[IW-1:0];
        if (jp_sum < {1'b0, n}) begin
          wr_en   = 1'b1;
          wr_addr = jp_sum[IW-1:0];
          wr_data = rd_data;
          j_nxt   = j_r + 1'b1;
        end else begin
          i_nxt     = n;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // rightmost symbol below k-1
        rd_addr = i_m1[IW-1:0];
        if (i_r == '0) begin
          clr       = 1'b1;
          p_nxt     = NW'(1);
          e_nxt     = '0;
          last_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else if (CW'(rd_data) >= k_m1) begin
          i_nxt = i_m1;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = i_m1[IW-1:0];
          wr_data   = rd_data + 1'b1;
          p_nxt     = i_r;
          rem_nxt   = n;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // does the new prefix length divide the order
        if (rem_r == '0) begin
          e_nxt     = '0;
          last_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end else if (rem_r < p_r) begin
          j_nxt     = '0;
          state_nxt = ST_COPY;
        end else begin
          rem_nxt = rem_r - p_r;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p_r         <= NW'(1);
      e_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (cfg_restart) begin
      state_r     <= state_nxt;
      p_r         <= NW'(1);
      e_r         <= '0;
      out_valid_r <= out_valid_nxt;
    end else begin
      state_r     <= state_nxt;
      p_r         <= p_nxt;
      e_r         <= e_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Necklace storage, cleared as a whole on restart
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart || clr) begin
      for (int x = 0; x < MAX_ORDER; x++) begin
        nk_r[x] <= '0;
      end
    end else if (wr_en) begin
      nk_r[wr_addr] <= wr_data;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    j_r    <= j_nxt;
    i_r    <= i_nxt;
    rem_r  <= rem_nxt;
    sym_r  <= sym_nxt;
    last_r <= last_nxt;
    if (out_load) begin
      out_sym_r  <= sym_r;
      out_last_r <= last_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.symbol   = out_sym_r;
  assign out_ch.fragment = (out_sym_r == '0) ? FRAG_ZERO : FRAG_OTHER;
  assign out_ch.last     = out_last_r;

endmodule
`default_nettype wire

[dv/tb_de_bruijn_fragment_generator.sv]
// Self-checking testbench for the de Bruijn fragment generator.
`timescale 1ns / 1ps
module tb_de_bruijn_fragment_generator;
  import dbfg_pkg::*;

  localparam int TOTAL_REQUESTS = 1850;
  localparam int QUIET_TAIL     = 200;   // last requests run without idling
  localparam int SETTLE_CYCLES  = 2000;  // quiet margin after the last result of a phase
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 4'd15;

  typedef struct {
    logic [DEF_SYMBOL_BITS-1:0] symbol;
    logic [FRAG_W-1:0]          fragment;
    logic                       last;
  } symbol_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dbfg_req_if in_ch ();
  dbfg_rsp_if #(.SYMBOL_BITS(DEF_SYMBOL_BITS)) out_ch ();
  dbfg_cfg_if cfg_ch ();

  de_bruijn_fragment_generator #(
    .MAX_ORDER  (DEF_MAX_ORDER),
    .SYMBOL_BITS(DEF_SYMBOL_BITS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the generator state and its registers
  logic [DEF_SYMBOL_BITS-1:0] neck [DEF_MAX_ORDER];
  int unsigned prefix_len;
  int unsigned emit_pos;
  logic [CFG_DATA_W-1:0] alphabet_reg;
  logic [CFG_DATA_W-1:0] order_reg;

  bit          pending_restarts [$];
  symbol_rec_t expected_symbols [$];
  int          requests_sent = 0;
  int          symbols_seen = 0;
  int          error_count = 0;
  bit          idle_on = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;

  function automatic int eff_alphabet();
    if (alphabet_reg < 2) return 2;
    if (alphabet_reg > (1 << DEF_SYMBOL_BITS)) return 1 << DEF_SYMBOL_BITS;
    return alphabet_reg;
  endfunction

  function automatic int eff_order();
    if (order_reg < 1) return 1;
    if (order_reg > DEF_MAX_ORDER) return DEF_MAX_ORDER;
    return order_reg;
  endfunction

  function automatic void seq_restart();
    foreach (neck[i]) neck[i] = '0;
    prefix_len = 1;
    emit_pos   = 0;
  endfunction

  // Walk to the next prefix whose length divides the order; 1 on wrap
  function automatic bit seq_advance();
    int n;
    int k;
    int p;
    int i;
    n = eff_order();
    k = eff_alphabet();
    p = prefix_len;
    do begin
      for (int j = 0; j + p < n; j++) neck[p + j] = neck[j];
      i = n;
      while (i > 0 && int'(neck[i - 1]) >= k - 1) i--;
      if (i == 0) begin
        seq_restart();
        return 1'b1;
      end
      neck[i - 1] = neck[i - 1] + 1'b1;
      p = i;
    end while (n % p != 0);
    prefix_len = p;
    emit_pos   = 0;
    return 1'b0;
  endfunction

  // Expected symbol for one accepted request
  function automatic void next_symbol(input logic restart);
    symbol_rec_t rec;
    if (restart) seq_restart();
    if (prefix_len == 0 || prefix_len > eff_order() || emit_pos >= prefix_len) seq_restart();
    rec.symbol   = neck[emit_pos];
    rec.fragment = (rec.symbol == '0) ? FRAG_ZERO : FRAG_OTHER;
    rec.last     = 1'b0;
    emit_pos++;
    if (emit_pos >= prefix_len) rec.last = seq_advance();
    expected_symbols.insert(expected_symbols.size(), rec);
  endfunction

  function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_ALPHABET_SIZE) begin
      alphabet_reg = val;
      seq_restart();
    end else if (idx == REG_ORDER) begin
      order_reg = val;
      seq_restart();
    end
  endfunction

  // Request driver: pops pending requests, random bursts of idle cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.restart <= 1'b0;
      in_gap        <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) next_symbol(in_ch.restart);
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_ch.valid <= 1'b0;
          in_gap      <= in_gap - 1;
        end else if (pending_restarts.size() > 0) begin
          if (idle_on && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            in_gap      <= $urandom_range(0, 14);
          end else begin
            in_ch.valid   <= 1'b1;
            in_ch.restart <= pending_restarts.pop_front();
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random stalls, compare against oldest expectation
  always @(posedge clk) begin
    symbol_rec_t exp_rec;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        symbols_seen++;
        if (expected_symbols.size() == 0) begin
          $display("%0t: unexpected result: expected none, got symbol %0d fragment %0d last %0b",
                   $time, out_ch.symbol, out_ch.fragment, out_ch.last);
          error_count++;
        end else begin
          exp_rec = expected_symbols.pop_front();
          if (out_ch.symbol !== exp_rec.symbol) begin
            $display("%0t: symbol mismatch: expected %0d, got %0d",
                     $time, exp_rec.symbol, out_ch.symbol);
            error_count++;
          end
          if (out_ch.fragment !== exp_rec.fragment) begin
            $display("%0t: fragment mismatch: expected %b, got %b",
                     $time, exp_rec.fragment, out_ch.fragment);
            error_count++;
          end
          if (out_ch.last !== exp_rec.last) begin
            $display("%0t: last mismatch: expected %0b, got %0b",
                     $time, exp_rec.last, out_ch.last);
            error_count++;
          end
        end
      end
      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall    <= out_stall - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        out_stall    <= $urandom_range(0, 14);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_request(input bit restart);
    pending_restarts.insert(pending_restarts.size(), restart);
    requests_sent++;
  endtask

  // Wait for every result, then idle a while
  task automatic drain();
    while (symbols_seen < requests_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; held until ready, then applied to the shadow copy
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_reg_write(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int mode;
    int burst;
    int restart_odds;
    logic [CFG_DATA_W-1:0] k_val;
    logic [CFG_DATA_W-1:0] n_val;

    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    alphabet_reg  = ALPHABET_RESET;
    order_reg     = ORDER_RESET;
    seq_restart();

    repeat (12) @(posedge clk);
    rst_n   <= 1'b1;
    idle_on <= 1'b1;
    @(posedge clk);

    // Reset defaults, then a restart in mid prefix
    repeat (3) queue_request(1'b0);
    queue_request(1'b1);
    queue_request(1'b0);
    drain();

    // Alphabet and order below range clamp to k=2, n=1; wraps twice
    write_reg(REG_ALPHABET_SIZE, 5'd0);
    write_reg(REG_ORDER, 5'd0);
    repeat (4) queue_request(1'b0);
    drain();

    // Alphabet of one clamps to two, order two, past the wrap
    write_reg(REG_ALPHABET_SIZE, 5'd1);
    write_reg(REG_ORDER, 5'd2);
    repeat (5) queue_request(1'b0);
    drain();

    // Largest register values clamp to k=16, n=16
    write_reg(REG_ALPHABET_SIZE, 5'd31);
    write_reg(REG_ORDER, 5'd31);
    repeat (3) queue_request(1'b0);
    queue_request(1'b1);
    drain();

    // Unmapped index: no effect, sequence carries on
    write_reg(REG_UNMAPPED, 5'd31);
    repeat (2) queue_request(1'b0);
    drain();

    // Just above range on both registers
    write_reg(REG_ORDER, 5'd17);
    write_reg(REG_ALPHABET_SIZE, 5'd17);
    repeat (2) queue_request(1'b0);
    drain();

    // Full alphabet, order one
    write_reg(REG_ALPHABET_SIZE, 5'd16);
    write_reg(REG_ORDER, 5'd1);
    repeat (3) queue_request(1'b0);
    drain();

    // Random phases: mostly long runs that wrap, some noisy restarts
    while (requests_sent < TOTAL_REQUESTS) begin
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
        k_val = CFG_DATA_W'($urandom_range(0, 3));
        n_val = CFG_DATA_W'($urandom_range(0, 4));
        burst = $urandom_range(30, 120);
      end else if (mode < 8) begin
        k_val = CFG_DATA_W'($urandom_range(2, 6));
        n_val = CFG_DATA_W'($urandom_range(1, 3));
        burst = $urandom_range(40, 150);
      end else begin
        k_val = CFG_DATA_W'($urandom_range(0, 31));
        n_val = CFG_DATA_W'($urandom_range(0, 31));
        burst = $urandom_range(10, 40);
      end

      if (TOTAL_REQUESTS - requests_sent <= QUIET_TAIL) idle_on <= 1'b0;
      else idle_on <= ($urandom_range(0, 3) != 0);

      if ($urandom_range(0, 4) == 0) begin
        write_reg(CFG_INDEX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom_range(0, 31)));
      end
      if ($urandom_range(0, 7) != 0) begin
        if ($urandom_range(0, 1) == 0) begin
          write_reg(REG_ALPHABET_SIZE, k_val);
          write_reg(REG_ORDER, n_val);
        end else begin
          write_reg(REG_ORDER, n_val);
          write_reg(REG_ALPHABET_SIZE, k_val);
        end
      end

      case ($urandom_range(0, 3))
        0: restart_odds = 4;
        1: restart_odds = 0;
        default: restart_odds = 32;
      endcase

      if (burst > TOTAL_REQUESTS - requests_sent) burst = TOTAL_REQUESTS - requests_sent;
      repeat (burst) begin
        queue_request(restart_odds != 0 && $urandom_range(0, restart_odds - 1) == 0);
      end
      drain();
    end

    if (error_count == 0 && expected_symbols.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(100_000_000);
    $display("%0t: timeout, %0d of %0d results seen", $time, symbols_seen, requests_sent);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
src/dbfg_pkg.sv
src/dbfg_if.sv
src/dbfg_front.sv
src/dbfg_back.sv
src/de_bruijn_fragment_generator.sv
dv/tb_de_bruijn_fragment_generator.sv
